/* hw/rtl/text_packet_deframer_macros.svh */
// assertion macros for the text packet deframer checker
`ifndef TEXT_PACKET_DEFRAMER_MACROS_SVH
`define TEXT_PACKET_DEFRAMER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpd check failed");

// antecedent implies consequent in the next cycle
`define TPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tpd check failed");

`endif

/* hw/rtl/tpd_pkg.sv */
// shared constants, types and helpers of the text packet deframer
package tpd_pkg;

    localparam int PAYLOAD_DEPTH = 128;
    localparam int AW            = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int CNT_W         = $clog2(PAYLOAD_DEPTH + 1);
    localparam int CMP_W         = (CNT_W > 8) ? CNT_W : 8;

    localparam logic [7:0] LEN_MAX = (PAYLOAD_DEPTH > 255) ? 8'd255 : 8'(PAYLOAD_DEPTH);

    localparam logic [1:0] REQ_BYTE    = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    localparam logic [1:0] CFG_START      = 2'd0;
    localparam logic [1:0] CFG_FIRST_END  = 2'd1;
    localparam logic [1:0] CFG_SECOND_END = 2'd2;

    localparam int OUT_DW = 24;

    typedef enum logic [1:0] {
        PH_SEEK    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TAIL    = 2'd2
    } t_phase;

    typedef struct packed {
        logic       ready;
        logic [7:0] length;
        logic       ovf;
        t_phase     phase;
        logic       rd_hit;
    } t_ctrl_stat;

    function automatic logic [7:0] sat_len(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+7:0] wide;
        wide = {8'd0, cnt};
        if (wide > (CNT_W+8)'(255)) begin
            sat_len = 8'd255;
        end else begin
            sat_len = wide[7:0];
        end
    endfunction

endpackage

/* hw/rtl/tpd_ram.sv */
// generic single-write single-read ram with registered read data
module tpd_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/tpd_frame_ctrl.sv */
// framing state machine, counters, flags and marker registers
module tpd_frame_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [7:0]               i_cfg_data,
    input  logic                     i_accept,
    input  logic [1:0]               i_req,
    input  logic [7:0]               i_byte,
    input  logic [6:0]               i_idx,
    output logic                     o_we,
    output logic [tpd_pkg::AW-1:0]   o_waddr,
    output logic [7:0]               o_wdata,
    output logic                     o_re,
    output logic [tpd_pkg::AW-1:0]   o_raddr,
    output tpd_pkg::t_ctrl_stat      o_stat
);
    import tpd_pkg::*;

    logic [7:0]       r_start, r_first, r_second;
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ready, n_ready;
    logic             r_ovf, n_ovf;
    logic             room;
    logic             store;
    logic             rd_hit;
    logic [CMP_W-1:0] idx_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= 8'd64;
            r_first  <= 8'd13;
            r_second <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START:      r_start  <= i_cfg_data;
                CFG_FIRST_END:  r_first  <= i_cfg_data;
                CFG_SECOND_END: r_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign room    = r_count < CNT_W'(PAYLOAD_DEPTH);
    assign idx_ext = CMP_W'(i_idx);
    assign rd_hit  = (i_req == REQ_READ) && (idx_ext < CMP_W'(r_count))
                     && (idx_ext < CMP_W'(PAYLOAD_DEPTH));

    // next state
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_ready = r_ready;
        n_ovf   = r_ovf;
        case (i_req)
            REQ_BYTE: begin
                case (r_phase)
                    PH_PAYLOAD: begin
                        if (i_byte == r_first) begin
                            n_phase = PH_TAIL;
                        end else if (room) begin
                            n_count = r_count + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    PH_TAIL: begin
                        if (i_byte == r_second) begin
                            n_phase = PH_SEEK;
                            n_ready = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_SEEK;
                        if (i_byte == r_start && !r_ready) begin
                            n_phase = PH_PAYLOAD;
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                    end
                endcase
            end
            REQ_RELEASE: n_ready = 1'b0;
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        store = (i_req == REQ_BYTE) && (r_phase == PH_PAYLOAD)
                && (i_byte != r_first) && room;
        o_we          = i_accept && store;
        o_waddr       = AW'(r_count);
        o_wdata       = i_byte;
        o_re          = i_accept && rd_hit;
        o_raddr       = AW'(idx_ext);
        o_stat.ready  = n_ready;
        o_stat.length = sat_len(n_count);
        o_stat.ovf    = n_ovf;
        o_stat.phase  = n_phase;
        o_stat.rd_hit = rd_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_count <= '0;
            r_ready <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_ready <= n_ready;
            r_ovf   <= n_ovf;
        end
    end

endmodule

/* hw/rtl/text_packet_deframer.sv */
// text packet deframer top level: request pipeline around the payload ram
// usage
// - slave stream carries requests: tuser is the request kind (received byte,
//   read stored byte, release packet), tdata the byte value and read index
// - master stream returns one item per request with the state after it:
//   ready flag, length, read byte, overflow flag and receive phase
// - config channel writes the start, first end and second end markers;
//   o_cfg_ready is always high, write only while no request is in flight
// - between request accept and result valid an item passes the stage-one
//   register beside the ram read register, then the output register
// - throughput is one item per cycle unless the receiver stalls; an item does
//   at most one ram write or read; a write is visible to the next item's read
// - when the receiver stalls, the output register holds its item and the
//   pipeline stage behind it fills, then o_s_tready drops
// - synchronous reset clears phase, count and flags and restores the default
//   markers; ram contents stay undefined and entries past the length read as
//   zero
module text_packet_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // byte_value[7:0], read_index[14:8], zero pad
    input  logic [1:0]  i_s_tuser,   // req_type[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // packet_ready[0], packet_length[8:1],
                                     // read_byte[16:9], overflow_seen[17],
                                     // receive_phase[19:18], zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import tpd_pkg::*;

    logic          accept;
    logic          s1_move;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;
    t_ctrl_stat    stat;

    logic              r_s1_valid;
    t_ctrl_stat        r_s1_stat;
    logic              r_out_valid;
    logic [OUT_DW-1:0] r_out_data;

    assign o_cfg_ready = 1'b1;
    assign s1_move     = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_s1_valid || s1_move;
    assign accept      = i_s_tvalid && o_s_tready;

    tpd_frame_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_req       (i_s_tuser),
        .i_byte      (i_s_tdata[7:0]),
        .i_idx       (i_s_tdata[14:8]),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .o_stat      (stat)
    );

    tpd_ram #(
        .DEPTH (PAYLOAD_DEPTH),
        .AW    (AW),
        .DW    (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_stat <= stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= {4'd0, r_s1_stat.phase, r_s1_stat.ovf,
                           (r_s1_stat.rd_hit ? rdata : 8'd0),
                           r_s1_stat.length, r_s1_stat.ready};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

/* hw/rtl/tpd_checker.sv */
// port-level checker for the text packet deframer and its bind
`include "text_packet_deframer_macros.svh"

module tpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);
    import tpd_pkg::*;

    // stalled result holds
    `TPD_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // dropped bytes only once the buffer is full
    `TPD_ASSERT_NOW(a_ovf_full, o_m_tvalid && o_m_tdata[17], o_m_tdata[8:1] == LEN_MAX)

    // no finished packet while a packet is being received
    `TPD_ASSERT_NOW(a_ready_seek, o_m_tvalid && (o_m_tdata[19:18] != 2'd0), !o_m_tdata[0])

endmodule

bind text_packet_deframer tpd_checker u_tpd_checker (.*);
